// ===== hw/rtl/ptf_pkg.sv =====
`timescale 1ns / 1ps
package ptf_pkg;

  localparam int VIRTUAL_PAGES   = 256;
  localparam int PHYSICAL_FRAMES = 32;
  localparam int PAGE_W  = $clog2(VIRTUAL_PAGES);
  localparam int FRAME_W = (PHYSICAL_FRAMES > 1) ? $clog2(PHYSICAL_FRAMES) : 1;
  localparam int STAMP_W = 64;
  localparam int CNT_W   = 32;

  localparam logic CMD_RESOLVE = 1'b0;
  localparam logic CMD_TOUCH   = 1'b1;

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [PAGE_W-1:0] page_index;
    logic              write_access;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_index;
    logic               was_hit;
    logic               did_evict;
    logic [PAGE_W-1:0]  evicted_page;
    logic [CNT_W-1:0]   hit_total;
    logic [CNT_W-1:0]   fault_total;
    logic [CNT_W-1:0]   evict_total;
  } rsp_t;

  // running search state handed from cell to cell
  typedef struct packed {
    logic               free_found;
    logic [FRAME_W-1:0] free_frame;
    logic               vic_found;
    logic [STAMP_W-1:0] vic_stamp;
    logic [FRAME_W-1:0] vic_frame;
    logic [PAGE_W-1:0]  vic_page;
  } scan_t;

  // update command broadcast to the cells
  typedef struct packed {
    logic               load;
    logic               touch;
    logic [FRAME_W-1:0] frame;
    logic [PAGE_W-1:0]  page;
    logic [STAMP_W-1:0] stamp;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_FILL,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/ptf_ram.sv =====
`timescale 1ns / 1ps
module ptf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ptf_cell.sv =====
`timescale 1ns / 1ps
module ptf_cell import ptf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [FRAME_W-1:0] frame_id,
  input  logic               mode,
  input  cell_ctl_t          ctl,
  input  scan_t              carry_in,
  output scan_t              carry_out
);

  logic               owner_valid;
  logic [PAGE_W-1:0]  owner_page;
  logic [STAMP_W-1:0] load_stamp;
  logic [STAMP_W-1:0] use_stamp;
  logic [STAMP_W-1:0] stamp;
  scan_t              carry_next;

  // hold the frame's owner and its stamps
  always_ff @(posedge clk) begin
    if (rst) begin
      owner_valid <= 1'b0;
    end else if (ctl.load && ctl.frame == frame_id) begin
      owner_valid <= 1'b1;
    end
    if (ctl.load && ctl.frame == frame_id) begin
      owner_page <= ctl.page;
      load_stamp <= ctl.stamp;
      use_stamp  <= ctl.stamp;
    end else if (ctl.touch && ctl.frame == frame_id) begin
      use_stamp <= ctl.stamp;
    end
  end

  // merge this frame into the running search
  always_comb begin
    stamp      = (mode == MODE_LRU) ? use_stamp : load_stamp;
    carry_next = carry_in;
    if (!owner_valid) begin
      if (!carry_in.free_found) begin
        carry_next.free_found = 1'b1;
        carry_next.free_frame = frame_id;
      end
    end else if (!carry_in.vic_found || stamp < carry_in.vic_stamp) begin
      carry_next.vic_found = 1'b1;
      carry_next.vic_stamp = stamp;
      carry_next.vic_frame = frame_id;
      carry_next.vic_page  = owner_page;
    end
  end

  // advance one cell per cycle
  always_ff @(posedge clk) begin
    carry_out <= carry_next;
  end

endmodule

// ===== hw/rtl/page_table_fifo_lru_replacement.sv =====
`timescale 1ns / 1ps
// A hit or a touch goes from ST_LOOK to ST_DONE; a fault goes on through ST_SCAN, where
// the search walks the row of 32 frame cells, one per cycle, then ST_FILL and ST_DONE.
// One item at a time; the next input is taken the cycle after the result transfers.
// Reset (rst, synchronous): all pages and frames free, counters, clock and mode cleared.
module page_table_fifo_lru_replacement import ptf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_data,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  state_t             state, state_next;
  logic               mode;
  req_t               cur;
  logic [STAMP_W-1:0] access_clock;
  logic [CNT_W-1:0]   hit_count, fault_count, evict_count;
  logic [VIRTUAL_PAGES-1:0] page_valid;
  logic [FRAME_W-1:0] scan_cnt;
  logic [FRAME_W-1:0] ram_rdata;
  logic [FRAME_W-1:0] fill_frame;
  logic               res_load;
  rsp_t               res;
  cell_ctl_t          ctl;
  scan_t              carry [PHYSICAL_FRAMES+1];

  assign carry[0]   = '0;
  assign req_stall  = (state != ST_IDLE);
  assign rsp_valid  = (state == ST_DONE);
  assign fill_frame = carry[PHYSICAL_FRAMES].free_found ?
                      carry[PHYSICAL_FRAMES].free_frame : carry[PHYSICAL_FRAMES].vic_frame;

  // page frame table
  ptf_ram #(.WIDTH(FRAME_W), .DEPTH(VIRTUAL_PAGES)) u_frame_ram (
    .clk   (clk),
    .we    (state == ST_FILL),
    .waddr (cur.page_index),
    .wdata (fill_frame),
    .raddr (req.page_index),
    .rdata (ram_rdata)
  );

  // row of frame cells
  for (genvar i = 0; i < PHYSICAL_FRAMES; i++) begin : g_cell
    ptf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .frame_id  (FRAME_W'(i)),
      .mode      (mode),
      .ctl       (ctl),
      .carry_in  (carry[i]),
      .carry_out (carry[i+1])
    );
  end

  // next state, cell commands and result
  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.page   = cur.page_index;
    ctl.stamp  = access_clock;
    res        = '0;
    res_load   = 1'b0;
    res.hit_total   = hit_count;
    res.fault_total = fault_count;
    res.evict_total = evict_count;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_LOOK;
      end
      ST_LOOK: begin
        if (cur.cmd == CMD_TOUCH || page_valid[cur.page_index]) begin
          ctl.touch = page_valid[cur.page_index];
          ctl.frame = ram_rdata;
          res_load  = 1'b1;
          res.frame_index = page_valid[cur.page_index] ? ram_rdata : '0;
          if (cur.cmd == CMD_RESOLVE) begin
            res.was_hit   = 1'b1;
            res.hit_total = hit_count + 1'b1;
          end
          state_next = ST_DONE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt == FRAME_W'(PHYSICAL_FRAMES-1)) state_next = ST_FILL;
      end
      ST_FILL: begin
        ctl.load  = 1'b1;
        ctl.frame = fill_frame;
        res_load  = 1'b1;
        res.frame_index = fill_frame;
        res.fault_total = fault_count + 1'b1;
        if (!carry[PHYSICAL_FRAMES].free_found) begin
          res.did_evict    = 1'b1;
          res.evicted_page = carry[PHYSICAL_FRAMES].vic_page;
          res.evict_total  = evict_count + 1'b1;
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      mode         <= MODE_FIFO;
      access_clock <= '0;
      hit_count    <= '0;
      fault_count  <= '0;
      evict_count  <= '0;
      page_valid   <= '0;
      scan_cnt     <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) mode <= cfg_data;
      if (state == ST_IDLE && req_valid) access_clock <= access_clock + 1'b1;
      if (state == ST_SCAN) scan_cnt <= scan_cnt + 1'b1;
      else scan_cnt <= '0;
      if (res_load) begin
        hit_count   <= res.hit_total;
        fault_count <= res.fault_total;
        evict_count <= res.evict_total;
      end
      if (state == ST_FILL) begin
        if (!carry[PHYSICAL_FRAMES].free_found)
          page_valid[carry[PHYSICAL_FRAMES].vic_page] <= 1'b0;
        page_valid[cur.page_index] <= 1'b1;
      end
    end
  end

  // hold the item and its result
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) cur <= req;
    if (res_load) rsp <= res;
  end

endmodule
